@@ sv/tmwf_pkg.sv @@
// Shared types and constants of the trimmed-mean window filter.
`timescale 1ns / 1ps

package tmwf_pkg;

  // Default configuration.
  localparam int WINDOW_LEN_DEF   = 10;
  localparam int NUM_CHANNELS_DEF = 6;

  // Field widths and stream bus packing.
  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 24;
  localparam int TDATA_W   = 32;
  localparam int CH_LSB    = 0;
  localparam int SMP_LSB   = CHANNEL_W;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_TRIM,
    ST_MUL,
    ST_BACK,
    ST_FIX,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic scan;
    logic trim;
    logic mul;
    logic back;
    logic fix;
    logic zero_res;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chan_ok;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

@@ sv/trimmed_mean_window_filter_top.sv @@
// Top level of the per-channel moving-window trimmed-mean filter.
`timescale 1ns / 1ps

// Each input request carries a channel number and a signed 24-bit sample. The
// sample replaces the oldest entry of that channel's window of the last
// WINDOW_LEN samples; the block returns one result per request: the channel
// number and the window sum with one smallest and one largest entry removed,
// divided by WINDOW_LEN-2 and truncated toward zero, in the sample's scaling.
// Windows read as zero after reset. A channel number at or above NUM_CHANNELS
// leaves every window unchanged and returns a result of zero for that channel.
// One request is processed at a time: the sample is written first, then the window scan reads
// one entry per cycle from a single-port window memory, a trim and constant divider follows
// through its trim, multiply, back-multiply and fix states, and the output register is loaded
// once it is free. The next request is accepted in the cycle after that load at the earliest.
// A new request is accepted as soon as the previous one has been loaded into
// the output register, even while that result still waits on out_tready.
// No clearing pass is needed after reset; per-channel fill tracking masks
// entries that have not been written yet.

module trimmed_mean_window_filter_top #(
  parameter int WINDOW_LEN   = tmwf_pkg::WINDOW_LEN_DEF,
  parameter int NUM_CHANNELS = tmwf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tmwf_pkg::TDATA_W-1:0] in_tdata,   // [2:0] channel, [26:3] sample
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tmwf_pkg::TDATA_W-1:0] out_tdata   // [2:0] channel_out, [26:3] filtered
);

  tmwf_pkg::cmd_t    cmd;
  tmwf_pkg::status_t st;

  // The controller sequences write, scan, divide and output steps.
  tmwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the windows, the running sum and extremes, and the divider.
  tmwf_datapath #(
    .WINDOW_LEN   (WINDOW_LEN),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/tmwf_ctrl.sv @@
// Controller state machine of the trimmed-mean window filter.
`timescale 1ns / 1ps

module tmwf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tmwf_pkg::status_t st,
  output tmwf_pkg::cmd_t    cmd
);

  tmwf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmwf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tmwf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = tmwf_pkg::ST_WRITE;
        end
      end
      tmwf_pkg::ST_WRITE: begin
        // A channel outside the window set leaves the state alone and returns zero.
        if (st.chan_ok) begin
          cmd.write = 1'b1;
          state_nxt = tmwf_pkg::ST_SCAN;
        end else begin
          cmd.zero_res = 1'b1;
          state_nxt    = tmwf_pkg::ST_DONE;
        end
      end
      tmwf_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = tmwf_pkg::ST_TRIM;
        end
      end
      tmwf_pkg::ST_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = tmwf_pkg::ST_MUL;
      end
      tmwf_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = tmwf_pkg::ST_BACK;
      end
      tmwf_pkg::ST_BACK: begin
        cmd.back  = 1'b1;
        state_nxt = tmwf_pkg::ST_FIX;
      end
      tmwf_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = tmwf_pkg::ST_DONE;
      end
      tmwf_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = tmwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tmwf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/tmwf_datapath.sv @@
// Datapath of the trimmed-mean window filter: window memory, scan, divider, output register.
`timescale 1ns / 1ps

module tmwf_datapath #(
  parameter int WINDOW_LEN   = tmwf_pkg::WINDOW_LEN_DEF,
  parameter int NUM_CHANNELS = tmwf_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tmwf_pkg::TDATA_W-1:0] in_tdata,
  input  tmwf_pkg::cmd_t               cmd,
  output tmwf_pkg::status_t            st,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tmwf_pkg::TDATA_W-1:0] out_tdata
);

  localparam int SW       = tmwf_pkg::SAMPLE_W;
  localparam int CHW      = tmwf_pkg::CHANNEL_W;
  localparam int DEPTH    = NUM_CHANNELS * WINDOW_LEN;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW       = $clog2(WINDOW_LEN);
  localparam int CW       = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W    = SW + $clog2(WINDOW_LEN);
  localparam int MAG_W    = SUM_W - 1;
  localparam int DIVISOR  = WINDOW_LEN - 2;
  localparam int DIV_W    = PW;
  localparam int RECIP_W  = MAG_W + 1;
  localparam int PROD_W   = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << MAG_W) / DIVISOR);
  localparam logic [DIV_W-1:0]   DIV_C   = DIV_W'(DIVISOR);
  localparam logic [PW-1:0]      LAST_IX = PW'(WINDOW_LEN - 1);

  // Request holding registers.
  logic [CHW-1:0]       ch_r;
  logic signed [SW-1:0] sample_r;
  logic                 ch_ok_r;

  // Per-channel window bookkeeping.
  logic [PW-1:0]        ptr_r  [NUM_CHANNELS];
  logic                 full_r [NUM_CHANNELS];

  // Window memory.
  logic [SW-1:0]        mem [DEPTH];
  logic [SW-1:0]        rdata_r;

  // Scan.
  logic [CW-1:0]        rd_idx_r;
  logic                 proc_vld_r;
  logic [PW-1:0]        proc_idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SW-1:0] lo_r, hi_r;

  // Divide by the constant through a reciprocal.
  logic [MAG_W-1:0]       mag_r;
  logic                   neg_r;
  logic [PROD_W-1:0]      prod_r;
  logic [MAG_W-1:0]       q_r;
  logic [MAG_W+DIV_W-1:0] qd_r;
  logic signed [SW-1:0]   res_r;

  // Output register.
  logic                 out_valid_r;
  logic [CHW-1:0]       out_ch_r;
  logic [SW-1:0]        out_res_r;

  logic [CH_IDX_W-1:0]  ch_idx;
  logic [AW-1:0]        base;
  logic [PW-1:0]        ptr_cur;
  logic [PW-1:0]        ptr_next;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 rd_issue;
  logic                 entry_valid;
  logic signed [SW-1:0] val;
  logic signed [SUM_W:0] trim;
  logic [MAG_W-1:0]       q_raw;
  logic [MAG_W+DIV_W-1:0] rem;
  logic [MAG_W-1:0]       q_fix;

  assign ch_idx   = CH_IDX_W'(ch_r);
  assign base     = AW'(ch_idx * WINDOW_LEN);
  assign ptr_cur  = ptr_r[ch_idx];
  assign ptr_next = (ptr_cur == LAST_IX) ? '0 : ptr_cur + 1'b1;
  assign wr_addr  = base + AW'(ptr_cur);
  assign rd_addr  = base + AW'(rd_idx_r);
  assign rd_issue = cmd.scan && (rd_idx_r < CW'(WINDOW_LEN));

  // Entries are written in index order from reset on, so an entry has been
  // written once the window has wrapped or its index lies below the pointer.
  assign entry_valid = full_r[ch_idx] || (proc_idx_r < ptr_r[ch_idx]);
  assign val         = entry_valid ? $signed(rdata_r) : '0;

  assign trim  = (SUM_W+1)'(sum_r) - (SUM_W+1)'(lo_r) - (SUM_W+1)'(hi_r);
  assign q_raw = prod_r[MAG_W +: MAG_W];
  assign rem   = {{DIV_W{1'b0}}, mag_r} - qd_r;
  assign q_fix = (rem >= (MAG_W+DIV_W)'(DIVISOR)) ? q_r + 1'b1 : q_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_tdata[tmwf_pkg::CH_LSB +: CHW];
      sample_r <= $signed(in_tdata[tmwf_pkg::SMP_LSB +: SW]);
      ch_ok_r  <= 32'(in_tdata[tmwf_pkg::CH_LSB +: CHW]) < NUM_CHANNELS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ptr_r[i]  <= '0;
        full_r[i] <= 1'b0;
      end
    end else if (cmd.write) begin
      ptr_r[ch_idx] <= ptr_next;
      if (ptr_cur == LAST_IX) begin
        full_r[ch_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= sample_r;
    end
    if (rd_issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= rd_issue;
      if (cmd.write) begin
        rd_idx_r <= '0;
      end else if (rd_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= PW'(rd_idx_r);
    if (proc_vld_r) begin
      if (proc_idx_r == '0) begin
        sum_r <= SUM_W'(val);
        lo_r  <= val;
        hi_r  <= val;
      end else begin
        sum_r <= sum_r + SUM_W'(val);
        if (val < lo_r) begin
          lo_r <= val;
        end
        if (val > hi_r) begin
          hi_r <= val;
        end
      end
    end
  end

  // Magnitude times reciprocal undershoots the quotient by at most one; the
  // remainder check adds it back, and the sign is restored last.
  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      neg_r <= trim[SUM_W];
      mag_r <= MAG_W'(trim[SUM_W] ? -trim : trim);
    end
    if (cmd.mul) begin
      prod_r <= mag_r * RECIP;
    end
    if (cmd.back) begin
      q_r  <= q_raw;
      qd_r <= q_raw * DIV_C;
    end
    if (cmd.zero_res) begin
      res_r <= '0;
    end else if (cmd.fix) begin
      res_r <= neg_r ? -$signed(SW'(q_fix)) : $signed(SW'(q_fix));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r  <= ch_r;
      out_res_r <= res_r;
    end
  end

  assign st.chan_ok   = ch_ok_r;
  assign st.scan_done = proc_vld_r && (proc_idx_r == LAST_IX);
  assign st.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tmwf_pkg::TDATA_W - CHW - SW){1'b0}}, out_res_r, out_ch_r};

endmodule

@@ sv/tmwf_checker.sv @@
// Port-level checker of the trimmed-mean window filter and its binding.
`timescale 1ns / 1ps

module tmwf_checker #(
  parameter int NUM_CHANNELS = tmwf_pkg::NUM_CHANNELS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tmwf_pkg::TDATA_W-1:0] out_tdata
);

  // Requests accepted whose results have not been taken yet.
  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result presented without an outstanding request");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r == 2'd0 || (pend_r == 2'd1 && out_tvalid))
    else $error("request accepted while another is still in work");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("ready stayed high right after an accepted request");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (32'(out_tdata[2:0]) >= NUM_CHANNELS) |-> out_tdata[26:3] == 24'd0)
    else $error("nonzero result for an unused channel");

endmodule

bind trimmed_mean_window_filter_top tmwf_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_tmwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/trimmed_mean_window_filter_top_tb.sv @@
// Self-checking testbench for the per-channel trimmed-mean window filter.
`timescale 1ns / 1ps

module trimmed_mean_window_filter_top_tb;

  localparam int WIN       = tmwf_pkg::WINDOW_LEN_DEF;
  localparam int CHANS     = tmwf_pkg::NUM_CHANNELS_DEF;
  localparam int CHANNEL_W = tmwf_pkg::CHANNEL_W;
  localparam int SAMPLE_W  = tmwf_pkg::SAMPLE_W;
  localparam int TDATA_W   = tmwf_pkg::TDATA_W;
  localparam int CH_LSB    = tmwf_pkg::CH_LSB;
  localparam int SMP_LSB   = tmwf_pkg::SMP_LSB;
  localparam int N_RANDOM  = 1130;
  localparam int MAX_GAP   = 17;
  localparam int HOLD_AT   = 300;   // result count at which the long back-pressure starts
  localparam int HOLD_LEN  = 400;   // cycles of that back-pressure
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
    int unsigned          gap;      // idle cycles before this request is offered
  } request_t;

  typedef struct {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  mean;
  } filtered_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  request_t  pending_requests[$];
  filtered_t expected_means[$];

  // Model of the channel windows and their oldest-entry indexes.
  logic signed [SAMPLE_W-1:0] window_model[CHANS][WIN];
  int unsigned                oldest_idx[CHANS];

  int unsigned total_requests;
  int unsigned accepted_count;
  int unsigned off_range_count;
  int unsigned checked_count;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned gap_count;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned results_taken;
  request_t    next_req;

  trimmed_mean_window_filter_top #(
    .WINDOW_LEN  (WIN),
    .NUM_CHANNELS(CHANS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sum of the window minus one minimum and one maximum, over WIN-2, toward zero.
  function automatic logic [SAMPLE_W-1:0] trimmed_mean_of(int unsigned ch);
    longint sum;
    longint lo;
    longint hi;
    longint v;
    sum = 0;
    lo = window_model[ch][0];
    hi = window_model[ch][0];
    for (int k = 0; k < WIN; k++) begin
      v = window_model[ch][k];
      sum += v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    sum = (sum - lo - hi) / longint'(WIN - 2);
    return sum[SAMPLE_W-1:0];
  endfunction

  function automatic filtered_t filter_request(logic [CHANNEL_W-1:0] ch,
                                               logic [SAMPLE_W-1:0] smp);
    filtered_t r;
    r.channel = ch;
    r.mean = '0;
    if (ch < CHANS) begin
      window_model[ch][oldest_idx[ch]] = smp;
      oldest_idx[ch] = (oldest_idx[ch] + 1) % WIN;
      r.mean = trimmed_mean_of(ch);
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned style,
                                                      logic [SAMPLE_W-1:0] level);
    logic [SAMPLE_W-1:0] v;
    case (style)
      0: v = SAMPLE_W'($urandom);
      1: v = SAMPLE_W'($urandom_range(0, 400) - 200);
      2: v = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom) : level;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 24'h7FFFFF;
          1: v = 24'h800000;
          2: v = SAMPLE_W'(24'h7FFFFF - $urandom_range(0, 3));
          default: v = SAMPLE_W'(24'h800000 + $urandom_range(0, 3));
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_request(logic [CHANNEL_W-1:0] ch, logic [SAMPLE_W-1:0] smp,
                             int unsigned gap);
    request_t r;
    r.channel = ch;
    r.sample = smp;
    r.gap = gap;
    pending_requests.push_back(r);
    total_requests++;
  endtask

  // Sender: offers the queued requests, holding each until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_count = 0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_requests.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_count < pending_requests[0].gap) begin
        gap_count++;
        in_tvalid <= 1'b0;
      end else begin
        next_req = pending_requests.pop_front();
        in_tdata <= TDATA_W'({next_req.sample, next_req.channel});
        in_tvalid <= 1'b1;
        gap_count = 0;
      end
    end
  end

  // Receiver: random stalls per result, quiet stretches, and one long hold-off
  // that lets the block fill up and push back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      results_taken = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (results_taken == HOLD_AT) hold_left = HOLD_LEN;
        stall_left = (((results_taken / 80) % 3) == 2) ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    filtered_t want;
    logic [CHANNEL_W-1:0] got_ch;
    logic [SAMPLE_W-1:0]  got_mean;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        accepted_count++;
        if (in_tdata[CH_LSB +: CHANNEL_W] >= CHANS) off_range_count++;
        expected_means.push_back(filter_request(in_tdata[CH_LSB +: CHANNEL_W],
                                                in_tdata[SMP_LSB +: SAMPLE_W]));
      end
      if (out_tvalid && out_tready) begin
        got_ch = out_tdata[CH_LSB +: CHANNEL_W];
        got_mean = out_tdata[SMP_LSB +: SAMPLE_W];
        if (expected_means.size() == 0) begin
          $display("%0t: result with nothing expected, got channel %0d mean %0d",
                   $time, got_ch, $signed(got_mean));
          error_count++;
        end else begin
          want = expected_means.pop_front();
          checked_count++;
          if (got_ch !== want.channel) begin
            $display("%0t: channel mismatch, expected %0d got %0d",
                     $time, want.channel, got_ch);
            error_count++;
          end
          if (got_mean !== want.mean) begin
            $display("%0t: mean mismatch on channel %0d, expected %0d got %0d",
                     $time, want.channel, $signed(want.mean), $signed(got_mean));
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_means.size());
      $display("trimmed_mean_window_filter_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [CHANNEL_W-1:0] ch;
    logic [SAMPLE_W-1:0]  level;
    int unsigned          run_left;
    int unsigned          style;

    // Every window starts out as all zeros, like the block after reset.
    for (int c = 0; c < CHANS; c++) begin
      oldest_idx[c] = 0;
      for (int k = 0; k < WIN; k++) begin
        window_model[c][k] = '0;
      end
    end

    // Directed part: channels beyond the last one, full-scale extremes on one
    // channel, repeated extremes so only one copy of each is trimmed, and
    // alternating bit patterns.
    add_request(3'd6, 24'h7FFFFF, 0);
    add_request(3'd7, 24'h800000, 0);
    add_request(3'd0, 24'h7FFFFF, 0);
    add_request(3'd0, 24'h7FFFFF, 0);
    add_request(3'd0, 24'h800000, 0);
    add_request(3'd0, 24'h800000, 0);
    add_request(3'd0, 24'h7FFFFF, 0);
    add_request(3'd0, 24'h7FFFFF, 2);
    add_request(3'd0, 24'h555555, 0);
    add_request(3'd0, 24'hAAAAAA, 0);
    add_request(3'd0, 24'hFFFFFF, 5);
    add_request(3'd0, 24'h000001, 0);
    add_request(3'd0, 24'h7FFFFF, 0);
    add_request(3'd0, 24'h7FFFFF, 0);
    add_request(3'd1, 24'hFFFFFF, 1);
    add_request(3'd2, 24'h000007, 0);
    add_request(3'd3, 24'h800000, 0);
    add_request(3'd4, 24'h123456, 3);
    add_request(3'd5, 24'hEDCBA9, 0);
    add_request(3'd5, 24'hEDCBA9, 0);
    add_request(3'd7, 24'h000000, MAX_GAP);
    add_request(3'd6, 24'hFFFFFF, 0);
    add_request(3'd5, 24'h800001, 0);

    // Random part: runs on one channel so windows fill with related data.
    run_left = 0;
    ch = '0;
    style = 0;
    level = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 14);
        ch = ($urandom_range(0, 11) == 0) ? CHANNEL_W'($urandom_range(CHANS, 7))
                                          : CHANNEL_W'($urandom_range(0, CHANS - 1));
        style = $urandom_range(0, 3);
        level = SAMPLE_W'($urandom);
      end
      run_left--;
      add_request(ch, draw_sample(style, level),
                  (((i / 90) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_requests || expected_means.size() != 0) @(posedge clk);
    repeat (WIN + 24) @(posedge clk);

    $display("Sent %0d requests (%0d on channels past the last), checked %0d results.",
             accepted_count, off_range_count, checked_count);
    $display("Stimulus covered full-scale extremes, repeated extremes and one long stall.");
    if (error_count == 0) begin
      $display("trimmed_mean_window_filter_top_tb OK");
    end else begin
      $display("trimmed_mean_window_filter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
